@@ rtl/varint_zigzag_serializer_defines.svh @@
// Assertion macros for the serializer. They expect clk and rst in scope.
`ifndef VARINT_ZIGZAG_SERIALIZER_DEFINES_SVH
`define VARINT_ZIGZAG_SERIALIZER_DEFINES_SVH

// Checked only outside reset.
`define VZS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define VZS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/vzs_pkg.sv @@
`timescale 1ns / 1ps

package vzs_pkg;

  localparam logic [1:0] OP_FIXED  = 2'd0;
  localparam logic [1:0] OP_VARINT = 2'd1;
  localparam logic [1:0] OP_ZIGZAG = 2'd2;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam int unsigned MaxRun = 10;

  localparam logic [6:0] VARINT_LOW_MASK = 7'h7F;
  localparam logic [7:0] VARINT_MORE_BIT = 8'h80;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  size_code;
    logic [63:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } run_t;

endpackage

@@ rtl/varint_zigzag_serializer.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// item      item_valid/item_stall  item_data  (operation, size_code, value)
// run       run_valid/run_stall    run_data   (out_byte, last)
// config    cfg_we                 cfg_wdata  (little_endian)
//
// An item of n bytes (1 to 10) holds the run register until its last byte leaves,
// one byte a cycle when not stalled, and that sets the rate. The next item waits in
// the hold register and is loaded as the last byte of the current run leaves, so
// runs follow with no gap; an item with the unused operation code is dropped there.
// Reset (synchronous) empties both registers and selects big endian order.
// A stall on the run side stalls the item side once the hold register is full.

module varint_zigzag_serializer
  import vzs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_data,
  output logic  run_valid,
  input  logic  run_stall,
  output run_t  run_data,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);

  `include "varint_zigzag_serializer_defines.svh"

  logic        little_endian;
  logic        hold_valid;
  item_t       hold;
  logic [79:0] run_bytes;
  logic [3:0]  run_count;

  logic        emit_free;
  logic        hold_take;
  logic [79:0] enc_bytes;
  logic [3:0]  enc_count;

  assign emit_free  = (run_count == 4'd0) || ((run_count == 4'd1) && !run_stall);
  assign hold_take  = hold_valid && emit_free;
  assign item_stall = hold_valid && !emit_free;

  assign run_valid         = (run_count != 4'd0);
  assign run_data.out_byte = run_bytes[7:0];
  assign run_data.last     = (run_count == 4'd1);

  // Encoder: works on the held item in a single pass.
  always_comb begin
    logic [63:0] mask;
    logic [63:0] vm;
    logic [63:0] zz;
    logic [63:0] vv;
    logic [63:0] fb;
    logic [69:0] ext;
    logic [6:0]  grp [MaxRun];
    logic [3:0]  vcount;
    logic [79:0] vbytes;
    logic [3:0]  nbytes;
    logic [2:0]  idx;
    logic        neg;

    unique case (hold.size_code)
      SIZE_8:  mask = 64'h0000_0000_0000_00FF;
      SIZE_16: mask = 64'h0000_0000_0000_FFFF;
      SIZE_32: mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    vm = hold.value & mask;

    // The sign bit is the highest bit the mask keeps.
    unique case (hold.size_code)
      SIZE_8:  neg = vm[7];
      SIZE_16: neg = vm[15];
      SIZE_32: neg = vm[31];
      default: neg = vm[63];
    endcase
    zz = ((vm << 1) ^ {64{neg}}) & mask;
    vv = (hold.operation == OP_ZIGZAG) ? zz : vm;

    ext    = {6'b0, vv};
    vcount = 4'd1;
    for (int k = 0; k < MaxRun; k++) begin
      grp[k] = ext[7 * k +: 7] & VARINT_LOW_MASK;
      if (grp[k] != 7'd0) begin
        vcount = 4'(k + 1);
      end
    end
    for (int k = 0; k < MaxRun; k++) begin
      vbytes[8 * k +: 8] = ((vcount > 4'(k + 1)) ? VARINT_MORE_BIT : 8'h00) | {1'b0, grp[k]};
    end

    nbytes = 4'd1 << hold.size_code;
    fb     = 64'd0;
    for (int k = 0; k < 8; k++) begin
      idx = little_endian ? 3'(k) : 3'(nbytes - 4'd1 - 4'(k));
      if (4'(k) < nbytes) begin
        fb[8 * k +: 8] = vm[8 * idx +: 8];
      end
    end

    unique case (hold.operation)
      OP_FIXED: begin
        enc_bytes = {16'd0, fb};
        enc_count = nbytes;
      end
      OP_VARINT, OP_ZIGZAG: begin
        enc_bytes = vbytes;
        enc_count = vcount;
      end
      default: begin
        enc_bytes = 80'd0;
        enc_count = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
    end else if (cfg_we) begin
      little_endian <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      hold_valid <= 1'b1;
    end else if (hold_take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= 4'd0;
    end else if (hold_take) begin
      run_count <= enc_count;
    end else if (run_valid && !run_stall) begin
      run_count <= run_count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_take) begin
      run_bytes <= enc_bytes;
    end else if (run_valid && !run_stall) begin
      run_bytes <= {8'd0, run_bytes[79:8]};
    end
  end

  property run_steps_down;
    run_valid && !run_stall && run_count > 4'd1 |=> run_count == $past(run_count) - 4'd1;
  endproperty

  property reset_empties;
    rst |=> run_count == 4'd0 && !hold_valid;
  endproperty

  `VZS_CHECK(a_stall_only_when_held, item_stall |-> hold_valid, "item stalled, hold empty")
  `VZS_CHECK(a_run_steps_down, run_steps_down, "run count did not step down")
  `VZS_CHECK(a_run_bounded, run_count <= 4'(MaxRun), "run longer than ten bytes")
  `VZS_CHECK_ALWAYS(a_reset_empties, reset_empties, "reset left an item in flight")

endmodule
